[hw/rtl/lbps_pkg.sv]
// lbps_pkg: shared types and constants for the led blink pattern sequencer
// no dependencies; used by lbps_front, lbps_back, the top level and the testbench

package lbps_pkg;

	localparam int IDX_W = 6;
	localparam int VAL_W = 8;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 8;
	localparam int CMD_QUEUE_DEPTH = 4;
	localparam int RES_QUEUE_DEPTH = 2;
	localparam logic [7:0] ELAPSED_MAX = 8'd255;

	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_LOAD  = 2'd1;
	localparam logic [1:0] OP_START = 2'd2;
	localparam logic [1:0] OP_NONE  = 2'd3;

	localparam logic [1:0] MODE_IDLE    = 2'd0;
	localparam logic [1:0] MODE_TRIGGER = 2'd1;
	localparam logic [1:0] MODE_REPEAT  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_MODE        = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_USE_PATTERN = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_START_LEVEL = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DELAY_TICKS = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LEN = 3'd4;

	typedef enum logic [1:0] {
		KIND_TICK,
		KIND_LOAD,
		KIND_START,
		KIND_NOP
	} kind_t;

	typedef struct packed {
		kind_t            kind;
		logic [IDX_W-1:0] index;
		logic [VAL_W-1:0] value;
	} cmd_t;

	typedef struct packed {
		logic led_level;
		logic active;
	} res_t;

	typedef struct packed {
		logic [1:0] mode;
		logic       use_pattern;
		logic       start_level;
		logic [7:0] delay_ticks;
		logic [6:0] pattern_length;
	} cfg_t;

endpackage

[hw/rtl/lbps_ram.sv]
// lbps_ram: generic single write port ram with registered read
// no dependencies

module lbps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[hw/rtl/lbps_fifo.sv]
// lbps_fifo: small register based queue with occupancy count
// no dependencies; used for the command queue and the result queue

module lbps_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  logic [WIDTH-1:0]             wdata,
	input  logic                         pop,
	output logic [WIDTH-1:0]             rdata,
	output logic [$clog2(DEPTH+1)-1:0]   count
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH+1);

	logic [WIDTH-1:0] data_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			data_q[wr_ptr_q] <= wdata;
		end
	end

	assign rdata = data_q[rd_ptr_q];
	assign count = count_q;

endmodule

[hw/rtl/lbps_front.sv]
// lbps_front: input stage, accepts items and classifies them into commands
// depends on lbps_pkg

module lbps_front #(
	parameter int PATTERN_DEPTH = 64
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         push,
	output logic                                         full,
	input  logic [1:0]                                   operation,
	input  logic [lbps_pkg::IDX_W-1:0]                   entry_index,
	input  logic [lbps_pkg::VAL_W-1:0]                   entry_value,
	input  logic [$clog2(lbps_pkg::CMD_QUEUE_DEPTH+1)-1:0] cq_count,
	output logic                                         cmd_valid_s1,
	output lbps_pkg::cmd_t                               cmd_s1
);

	localparam int CNT_W = $clog2(lbps_pkg::CMD_QUEUE_DEPTH+1);

	logic [CNT_W:0]  in_flight;
	logic            accept;
	lbps_pkg::kind_t kind;

	assign in_flight = {1'b0, cq_count} + (CNT_W+1)'(cmd_valid_s1);
	assign full      = in_flight >= (CNT_W+1)'(lbps_pkg::CMD_QUEUE_DEPTH);
	assign accept    = push && !full;

	always_comb begin
		unique case (operation)
			lbps_pkg::OP_TICK:  kind = lbps_pkg::KIND_TICK;
			lbps_pkg::OP_LOAD:  kind = (32'(entry_index) < PATTERN_DEPTH) ?
				lbps_pkg::KIND_LOAD : lbps_pkg::KIND_NOP;
			lbps_pkg::OP_START: kind = lbps_pkg::KIND_START;
			lbps_pkg::OP_NONE:  kind = lbps_pkg::KIND_NOP;
			default:            kind = lbps_pkg::KIND_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid_s1 <= 1'b0;
		end else begin
			cmd_valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1.kind  <= kind;
			cmd_s1.index <= entry_index;
			cmd_s1.value <= entry_value;
		end
	end

endmodule

[hw/rtl/lbps_back.sv]
// lbps_back: executes commands, holds config, sequence state and pattern store
// depends on lbps_pkg and lbps_ram

module lbps_back #(
	parameter int PATTERN_DEPTH = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	input  logic [lbps_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [lbps_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                cmd_valid,
	input  lbps_pkg::cmd_t                      cmd,
	input  logic                                res_room,
	output logic                                exec,
	output lbps_pkg::res_t                      res
);

	localparam int AW = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;
	localparam int PW = $clog2(PATTERN_DEPTH+1);

	lbps_pkg::cfg_t cfg_q;

	logic          led_q, led_d;
	logic          next_q, next_d;
	logic          run_q, run_d;
	logic [7:0]    elapsed_q, elapsed_d;
	logic [PW-1:0] pos_q, pos_d;

	logic [PW-1:0] eff_len;
	logic [7:0]    el_inc;
	logic          is_trig;
	logic          is_rep;
	logic          wrap;
	logic [PW-1:0] cur_pos;
	logic [PW:0]   pos_inc;
	logic [7:0]    duration;

	logic          we;
	logic [AW-1:0] waddr;
	logic [AW-1:0] raddr;
	logic [7:0]    rdata;
	logic          byp_q;
	logic [7:0]    byp_data_q;

	assign exec    = cmd_valid && res_room;
	assign eff_len = (32'(cfg_q.pattern_length) < PATTERN_DEPTH) ?
		PW'(cfg_q.pattern_length) : PW'(PATTERN_DEPTH);
	assign el_inc  = (elapsed_q == lbps_pkg::ELAPSED_MAX) ? elapsed_q : elapsed_q + 8'd1;
	assign is_trig = cfg_q.mode == lbps_pkg::MODE_TRIGGER;
	assign is_rep  = cfg_q.mode == lbps_pkg::MODE_REPEAT;
	assign wrap    = pos_q >= eff_len;
	assign cur_pos = wrap ? '0 : pos_q;
	assign pos_inc = {1'b0, cur_pos} + (PW+1)'(1);

	assign we       = exec && (cmd.kind == lbps_pkg::KIND_LOAD);
	assign waddr    = AW'(cmd.index);
	assign raddr    = (pos_d >= eff_len) ? '0 : AW'(pos_d);
	assign duration = byp_q ? byp_data_q : rdata;

	lbps_ram #(
		.WIDTH(8),
		.DEPTH(PATTERN_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (cmd.value),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_comb begin
		led_d     = led_q;
		next_d    = next_q;
		run_d     = run_q;
		elapsed_d = elapsed_q;
		pos_d     = pos_q;
		if (exec) begin
			unique case (cmd.kind)
				lbps_pkg::KIND_TICK: begin
					elapsed_d = el_inc;
					if (run_q) begin
						if (!is_trig && !is_rep) begin
							run_d = 1'b0;
						end else if (!cfg_q.use_pattern) begin
							if (is_trig) begin
								if (cfg_q.delay_ticks == 8'd0 || el_inc >= cfg_q.delay_ticks) begin
									led_d = next_q;
									run_d = 1'b0;
								end
							end else if (cfg_q.delay_ticks != 8'd0 &&
								el_inc >= cfg_q.delay_ticks) begin
								led_d     = next_q;
								next_d    = !next_q;
								elapsed_d = 8'd0;
							end
						end else if (wrap && is_trig) begin
							run_d = 1'b0;
						end else begin
							pos_d = cur_pos;
							if (!(wrap && eff_len == '0) && el_inc >= duration) begin
								led_d     = next_q;
								next_d    = !next_q;
								elapsed_d = 8'd0;
								pos_d     = (is_rep && pos_inc >= (PW+1)'(eff_len)) ?
									'0 : PW'(pos_inc);
							end
						end
					end
				end
				lbps_pkg::KIND_START: begin
					run_d     = is_trig || is_rep;
					next_d    = cfg_q.start_level;
					elapsed_d = 8'd0;
					pos_d     = '0;
				end
				lbps_pkg::KIND_LOAD: begin
				end
				lbps_pkg::KIND_NOP: begin
				end
				default: begin
				end
			endcase
		end
	end

	assign res.led_level = led_d;
	assign res.active    = run_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q     <= '0;
			led_q     <= 1'b0;
			next_q    <= 1'b0;
			run_q     <= 1'b0;
			elapsed_q <= '0;
			pos_q     <= '0;
			byp_q     <= 1'b0;
		end else begin
			led_q     <= led_d;
			next_q    <= next_d;
			run_q     <= run_d;
			elapsed_q <= elapsed_d;
			pos_q     <= pos_d;
			byp_q     <= we && (waddr == raddr);
			if (cfg_valid) begin
				unique case (cfg_index)
					lbps_pkg::REG_MODE:        cfg_q.mode           <= cfg_data[1:0];
					lbps_pkg::REG_USE_PATTERN: cfg_q.use_pattern    <= cfg_data[0];
					lbps_pkg::REG_START_LEVEL: cfg_q.start_level    <= cfg_data[0];
					lbps_pkg::REG_DELAY_TICKS: cfg_q.delay_ticks    <= cfg_data;
					lbps_pkg::REG_PATTERN_LEN: cfg_q.pattern_length <= cfg_data[6:0];
					default: begin
					end
				endcase
			end
		end
	end

	// store write colliding with the prefetch address
	always_ff @(posedge clk) begin
		byp_data_q <= cmd.value;
	end

endmodule

[hw/rtl/led_blink_pattern_sequencer_core.sv]
// led_blink_pattern_sequencer_core: top level of the led blink pattern sequencer
// depends on lbps_pkg, lbps_fifo, lbps_front, lbps_back, lbps_ram
//
// channel   direction  handshake           payload
// input     in         push / full         operation, entry_index, entry_value
// result    out        empty / pop         led_level, active
// config    in         cfg_valid/cfg_ready cfg_index, cfg_data
//
// one item per cycle sustained while the result queue drains; an accepted item passes in order through
// the input register, the command queue and the sequence unit, which writes its result to the result queue
// a full result queue stalls the sequence unit; the command queue absorbs the input side
// arst_n clears control state and config; the pattern store is not cleared
// config writes are always ready and take effect on the next cycle

module led_blink_pattern_sequencer_core #(
	parameter int PATTERN_DEPTH = 64
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               push,
	output logic                               full,
	input  logic [1:0]                         operation,
	input  logic [lbps_pkg::IDX_W-1:0]         entry_index,
	input  logic [lbps_pkg::VAL_W-1:0]         entry_value,
	output logic                               empty,
	input  logic                               pop,
	output logic                               led_level,
	output logic                               active,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [lbps_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [lbps_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int CQ_CNT_W = $clog2(lbps_pkg::CMD_QUEUE_DEPTH+1);
	localparam int RQ_CNT_W = $clog2(lbps_pkg::RES_QUEUE_DEPTH+1);
	localparam int CMD_W    = $bits(lbps_pkg::cmd_t);
	localparam int RES_W    = $bits(lbps_pkg::res_t);

	logic                cmd_valid_s1;
	lbps_pkg::cmd_t      cmd_s1;
	logic [CQ_CNT_W-1:0] cq_count;
	logic [CMD_W-1:0]    cq_head;
	lbps_pkg::cmd_t      cmd_head;
	logic                exec;
	lbps_pkg::res_t      res;
	logic [RQ_CNT_W-1:0] rq_count;
	logic [RES_W-1:0]    rq_head;
	lbps_pkg::res_t      res_head;
	logic                res_room;

	assign cfg_ready = 1'b1;

	lbps_front #(
		.PATTERN_DEPTH(PATTERN_DEPTH)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.operation    (operation),
		.entry_index  (entry_index),
		.entry_value  (entry_value),
		.cq_count     (cq_count),
		.cmd_valid_s1 (cmd_valid_s1),
		.cmd_s1       (cmd_s1)
	);

	lbps_fifo #(
		.WIDTH(CMD_W),
		.DEPTH(lbps_pkg::CMD_QUEUE_DEPTH)
	) u_cmd_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_valid_s1),
		.wdata  (cmd_s1),
		.pop    (exec),
		.rdata  (cq_head),
		.count  (cq_count)
	);

	assign cmd_head = lbps_pkg::cmd_t'(cq_head);
	assign res_room = rq_count < RQ_CNT_W'(lbps_pkg::RES_QUEUE_DEPTH);

	lbps_back #(
		.PATTERN_DEPTH(PATTERN_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd_valid (cq_count != '0),
		.cmd       (cmd_head),
		.res_room  (res_room),
		.exec      (exec),
		.res       (res)
	);

	lbps_fifo #(
		.WIDTH(RES_W),
		.DEPTH(lbps_pkg::RES_QUEUE_DEPTH)
	) u_res_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (exec),
		.wdata  (res),
		.pop    (pop && !empty),
		.rdata  (rq_head),
		.count  (rq_count)
	);

	assign res_head  = lbps_pkg::res_t'(rq_head);
	assign empty     = rq_count == '0;
	assign led_level = res_head.led_level;
	assign active    = res_head.active;

endmodule

[tb/sv/tb_led_blink_pattern_sequencer_core.sv]
// tb_led_blink_pattern_sequencer_core: self-checking testbench for the led blink sequencer
// drives config writes, and ticks, pattern loads, starts and nops through the input queue; predicts led and active
// depends on lbps_pkg and led_blink_pattern_sequencer_core

module tb_led_blink_pattern_sequencer_core;
	timeunit 1ns;
	timeprecision 1ps;

	import lbps_pkg::*;

	localparam int PATTERN_DEPTH = 64;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int ITEM_TARGET = 1750;

	typedef struct packed {
		logic [1:0]       op;
		logic [IDX_W-1:0] index;
		logic [VAL_W-1:0] value;
	} led_cmd_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	logic [1:0] operation = OP_TICK;
	logic [IDX_W-1:0] entry_index = '0;
	logic [VAL_W-1:0] entry_value = '0;
	logic empty;
	logic pop = 1'b0;
	logic led_level;
	logic active;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = REG_MODE;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// register copies
	logic [1:0] reg_mode = MODE_IDLE;
	logic       reg_use_pattern = 1'b0;
	logic       reg_start_level = 1'b0;
	logic [7:0] reg_delay = '0;
	logic [6:0] reg_pattern_len = '0;

	// sequencer state
	logic       seq_led = 1'b0;
	logic       seq_next = 1'b0;
	logic       seq_running = 1'b0;
	logic [7:0] seq_elapsed = '0;
	logic [6:0] seq_pos = '0;
	logic [7:0] seq_durations [PATTERN_DEPTH];

	led_cmd_t pending_cmds [$];
	res_t expected_leds [$];

	bit cmd_accepted = 1'b0;
	bit res_accepted = 1'b0;
	bit push_steady = 1'b0;
	bit pop_steady = 1'b0;
	bit hold_request = 1'b0;
	int send_gap = 0;
	int pop_gap = 0;
	int hold_left = 0;
	int cfg_write_count = 0;
	int items_made = 0;
	int cmds_sent = 0;
	int results_seen = 0;
	int errors = 0;
	int cycle_count = 0;

	led_blink_pattern_sequencer_core #(
		.PATTERN_DEPTH(PATTERN_DEPTH)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.operation(operation),
		.entry_index(entry_index),
		.entry_value(entry_value),
		.empty(empty),
		.pop(pop),
		.led_level(led_level),
		.active(active),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic int gap_len(bit steady);
		int roll;
		if (steady)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 65)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [7:0] pick_ticks();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 8'($urandom_range(0, 4));
		if (roll < 90)
			return 8'($urandom_range(5, 12));
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic void add_cmd(logic [1:0] op, logic [IDX_W-1:0] idx, logic [VAL_W-1:0] val);
		led_cmd_t cmd;
		cmd.op = op;
		cmd.index = idx;
		cmd.value = val;
		pending_cmds.push_back(cmd);
		if (op != OP_NONE)
			items_made++;
	endfunction

	function automatic void toggle_led();
		seq_led = seq_next;
		seq_next = ~seq_next;
		seq_elapsed = '0;
	endfunction

	function automatic void sequencer_step(logic [1:0] op, logic [IDX_W-1:0] idx,
			logic [VAL_W-1:0] val);
		logic [6:0] eff_len;
		eff_len = (reg_pattern_len < PATTERN_DEPTH) ? reg_pattern_len : 7'(PATTERN_DEPTH);
		case (op)
			OP_TICK: begin
				if (seq_elapsed != ELAPSED_MAX)
					seq_elapsed++;
				if (seq_running) begin
					if (reg_mode != MODE_TRIGGER && reg_mode != MODE_REPEAT) begin
						seq_running = 1'b0;
					end else if (!reg_use_pattern) begin
						if (reg_mode == MODE_TRIGGER) begin
							if (reg_delay == 0 || seq_elapsed >= reg_delay) begin
								seq_led = seq_next;
								seq_running = 1'b0;
							end
						end else if (reg_delay != 0 && seq_elapsed >= reg_delay) begin
							toggle_led();
						end
					end else if (seq_pos >= eff_len && reg_mode == MODE_TRIGGER) begin
						seq_running = 1'b0;
					end else begin
						if (seq_pos >= eff_len)
							seq_pos = '0;
						if (eff_len != 0 && seq_elapsed >= seq_durations[seq_pos[5:0]]) begin
							toggle_led();
							seq_pos++;
							if (reg_mode == MODE_REPEAT && seq_pos >= eff_len)
								seq_pos = '0;
						end
					end
				end
			end
			OP_LOAD: begin
				if (idx < PATTERN_DEPTH)
					seq_durations[idx] = val;
			end
			OP_START: begin
				seq_running = (reg_mode == MODE_TRIGGER || reg_mode == MODE_REPEAT);
				seq_next = reg_start_level;
				seq_elapsed = '0;
				seq_pos = '0;
			end
			default: begin
			end
		endcase
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		int prior_writes;
		prior_writes = cfg_write_count;
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		while (cfg_write_count == prior_writes)
			@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (pending_cmds.size() != 0 || cmds_sent != results_seen)
			@(negedge clk);
	endtask

	always @(posedge clk) begin : sample
		res_t fresh;
		res_t oldest;
		cmd_accepted = arst_n && push && !full;
		res_accepted = arst_n && pop && !empty;
		if (arst_n && cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_MODE:        reg_mode = cfg_data[1:0];
				REG_USE_PATTERN: reg_use_pattern = cfg_data[0];
				REG_START_LEVEL: reg_start_level = cfg_data[0];
				REG_DELAY_TICKS: reg_delay = cfg_data[7:0];
				REG_PATTERN_LEN: reg_pattern_len = cfg_data[6:0];
				default: begin
				end
			endcase
			cfg_write_count++;
		end
		if (cmd_accepted) begin
			sequencer_step(operation, entry_index, entry_value);
			fresh.led_level = seq_led;
			fresh.active = seq_running;
			expected_leds.push_back(fresh);
		end
		if (res_accepted) begin
			results_seen++;
			if (expected_leds.size() == 0) begin
				$error("result with no item waiting: led_level %0d, active %0d", led_level, active);
				errors++;
			end else begin
				oldest = expected_leds.pop_front();
				if (led_level !== oldest.led_level) begin
					$error("led_level mismatch: expected %0d, actual %0d", oldest.led_level, led_level);
					errors++;
				end
				if (active !== oldest.active) begin
					$error("active mismatch: expected %0d, actual %0d", oldest.active, active);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("** led_blink_pattern_sequencer_core: FAILED **");
			$finish;
		end
	end

	// item driver
	always @(negedge clk) begin : driver
		led_cmd_t cmd;
		if (arst_n && !(push && !cmd_accepted)) begin
			if (cmd_accepted)
				send_gap = gap_len(push_steady);
			if (send_gap > 0) begin
				send_gap--;
				push <= 1'b0;
			end else if (pending_cmds.size() != 0) begin
				cmd = pending_cmds.pop_front();
				cmds_sent++;
				push <= 1'b1;
				operation <= cmd.op;
				entry_index <= cmd.index;
				entry_value <= cmd.value;
			end else begin
				push <= 1'b0;
			end
		end
	end

	// result receiver
	always @(negedge clk) begin
		if (arst_n) begin
			if (res_accepted)
				pop_gap = gap_len(pop_steady);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = 250;
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else if (pop_gap > 0) begin
				pop_gap--;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	initial begin : stimulus
		int phase;
		int seg_len;
		int roll;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		add_cmd(OP_TICK, '0, '0);
		add_cmd(OP_NONE, 6'h3f, 8'hff);
		add_cmd(OP_START, '0, '0);
		add_cmd(OP_LOAD, 6'd0, 8'd2);
		add_cmd(OP_LOAD, 6'd1, 8'd0);
		add_cmd(OP_LOAD, 6'd2, 8'd1);
		add_cmd(OP_LOAD, 6'd63, 8'd255);
		add_cmd(OP_TICK, 6'h3f, 8'hff);
		wait_drained();

		write_reg(REG_MODE, CFG_DATA_W'(MODE_TRIGGER));
		write_reg(REG_START_LEVEL, 8'd1);
		write_reg(REG_DELAY_TICKS, 8'd2);
		add_cmd(OP_START, '0, '0);
		repeat (3) add_cmd(OP_TICK, '0, '0);
		wait_drained();

		write_reg(REG_START_LEVEL, 8'd0);
		write_reg(REG_DELAY_TICKS, 8'd0);
		add_cmd(OP_START, '0, '0);
		add_cmd(OP_TICK, '0, '0);
		wait_drained();

		write_reg(REG_MODE, CFG_DATA_W'(MODE_REPEAT));
		write_reg(REG_USE_PATTERN, 8'd1);
		write_reg(REG_START_LEVEL, 8'd1);
		write_reg(REG_PATTERN_LEN, 8'd3);
		add_cmd(OP_START, '0, '0);
		repeat (6) add_cmd(OP_TICK, '0, '0);
		wait_drained();

		for (int i = 0; i < PATTERN_DEPTH; i++)
			add_cmd(OP_LOAD, IDX_W'(i), pick_ticks());
		wait_drained();

		for (phase = 0; items_made < ITEM_TARGET; phase++) begin
			push_steady = ($urandom_range(0, 3) == 0);
			pop_steady = ($urandom_range(0, 3) == 0);
			if (phase % 10 == 4) begin
				// let elapsed saturate under a silent repeat, then raise the delay to the top
				write_reg(REG_MODE, CFG_DATA_W'(MODE_REPEAT));
				write_reg(REG_USE_PATTERN, 8'd0);
				write_reg(REG_DELAY_TICKS, 8'd0);
				add_cmd(OP_START, IDX_W'($urandom()), VAL_W'($urandom()));
				repeat (270) add_cmd(OP_TICK, IDX_W'($urandom()), VAL_W'($urandom()));
				wait_drained();
				write_reg(REG_DELAY_TICKS, 8'd255);
				repeat (6) add_cmd(OP_TICK, IDX_W'($urandom()), VAL_W'($urandom()));
			end else if (phase % 10 == 8) begin
				write_reg(REG_MODE, CFG_DATA_W'($urandom_range(MODE_TRIGGER, MODE_REPEAT)));
				write_reg(REG_USE_PATTERN, 8'd1);
				write_reg(REG_START_LEVEL, CFG_DATA_W'($urandom_range(0, 1)));
				write_reg(REG_PATTERN_LEN, 8'd64);
				add_cmd(OP_START, IDX_W'($urandom()), VAL_W'($urandom()));
				repeat (120) add_cmd(OP_TICK, IDX_W'($urandom()), VAL_W'($urandom()));
			end else begin
				if (phase == 0 || $urandom_range(0, 1))
					write_reg(REG_MODE, CFG_DATA_W'($urandom_range(MODE_IDLE, MODE_REPEAT)));
				if (phase == 0 || $urandom_range(0, 1))
					write_reg(REG_USE_PATTERN, CFG_DATA_W'($urandom_range(0, 1)));
				if (phase == 0 || $urandom_range(0, 1))
					write_reg(REG_START_LEVEL, CFG_DATA_W'($urandom_range(0, 1)));
				if (phase == 0 || $urandom_range(0, 1))
					write_reg(REG_DELAY_TICKS, pick_ticks());
				if (phase == 0 || $urandom_range(0, 1)) begin
					roll = $urandom_range(0, 99);
					if (roll < 70)
						write_reg(REG_PATTERN_LEN, CFG_DATA_W'($urandom_range(0, 8)));
					else if (roll < 85)
						write_reg(REG_PATTERN_LEN, 8'd64);
					else
						write_reg(REG_PATTERN_LEN, CFG_DATA_W'($urandom_range(0, 64)));
				end
				if ($urandom_range(0, 99) < 85)
					add_cmd(OP_START, IDX_W'($urandom()), VAL_W'($urandom()));
				seg_len = (phase == 3) ? 80 : $urandom_range(15, 60);
				for (int k = 0; k < seg_len; k++) begin
					roll = $urandom_range(0, 99);
					if (roll < 86)
						add_cmd(OP_TICK, IDX_W'($urandom()), VAL_W'($urandom()));
					else if (roll < 94)
						add_cmd(OP_LOAD, IDX_W'($urandom_range(0, PATTERN_DEPTH - 1)),
							pick_ticks());
					else if (roll < 98)
						add_cmd(OP_START, IDX_W'($urandom()), VAL_W'($urandom()));
					else
						add_cmd(OP_NONE, IDX_W'($urandom()), VAL_W'($urandom()));
				end
				// receiver backs off while a full segment is still queued
				if (phase == 3)
					hold_request = 1'b1;
			end
			wait_drained();
		end

		wait_drained();
		repeat (10) @(negedge clk);
		if (errors == 0)
			$display("** led_blink_pattern_sequencer_core: PASSED **");
		else
			$display("** led_blink_pattern_sequencer_core: FAILED **");
		$finish;
	end

endmodule

[filelist.f]
hw/rtl/lbps_pkg.sv
hw/rtl/lbps_ram.sv
hw/rtl/lbps_fifo.sv
hw/rtl/lbps_front.sv
hw/rtl/lbps_back.sv
hw/rtl/led_blink_pattern_sequencer_core.sv
tb/sv/tb_led_blink_pattern_sequencer_core.sv
